>>> sv/baro_pkg.sv
`timescale 1ns / 1ps

package baro_pkg;

    localparam int BARO_QUEUE_DEPTH = 2;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;

    // register indexes on the configuration channel
    localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_P      = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LINEAR_P      = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TEMP_CROSS    = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TEMP_PRESS    = 8'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SQUARE_P      = 8'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_TEMP_SQUARE_P = 8'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_CUBE_P        = 8'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_TEMP_RATES    = 8'd7;

    // oversampling factors, indexed by rate code
    localparam logic [22:0] RATE_FACTOR [8] = '{
        23'd524288, 23'd1572864, 23'd3670016, 23'd7864320,
        23'd253952, 23'd516096,  23'd1040384, 23'd2088960
    };

    // factor for code k is d * 2^19 (k < 4) or d * 2^13 with d = 2^(k+1) - 1;
    // each entry is floor(2^31 / d)
    localparam logic [31:0] RATE_RECIP [8] = '{
        32'h80000000, 32'h2AAAAAAA, 32'h12492492, 32'h08888888,
        32'h04210842, 32'h02082082, 32'h01020408, 32'h00808080
    };

    typedef struct packed {
        logic signed [23:0] raw_pressure;
        logic signed [23:0] raw_temperature;
    } baro_item_t;

    typedef struct packed {
        logic signed [19:0] c00;
        logic signed [19:0] c10;
        logic signed [15:0] c01;
        logic signed [15:0] c11;
        logic signed [15:0] c20;
        logic signed [15:0] c21;
        logic signed [15:0] c30;
        logic signed [11:0] c0;
        logic signed [11:0] c1;
        logic        [2:0]  prate;
        logic        [2:0]  trate;
    } baro_coef_t;

endpackage

>>> sv/baro_front.sv
`timescale 1ns / 1ps

module baro_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [47:0]         s_tdata,   // raw_pressure [23:0], raw_temperature [47:24]
    input  logic [0:0]          s_tuser,   // temp_present [0]
    output logic                push_valid,
    input  logic                push_ready,
    output baro_pkg::baro_item_t push_item
);
    import baro_pkg::*;

    logic signed [23:0] last_raw_temp_reg;
    logic               xfer;

    assign s_tready   = push_ready;
    assign push_valid = s_tvalid;
    assign xfer       = s_tvalid && push_ready;

    // a sample without a new temperature takes the stored one
    always_comb begin
        push_item.raw_pressure    = $signed(s_tdata[23:0]);
        push_item.raw_temperature = s_tuser[0] ? $signed(s_tdata[47:24]) : last_raw_temp_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_raw_temp_reg <= '0;
        end else if (xfer && s_tuser[0]) begin
            last_raw_temp_reg <= $signed(s_tdata[47:24]);
        end
    end

endmodule

>>> sv/baro_queue.sv
`timescale 1ns / 1ps

module baro_queue #(
    parameter int DEPTH = baro_pkg::BARO_QUEUE_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push_valid,
    output logic                push_ready,
    input  baro_pkg::baro_item_t push_item,
    output logic                pop_valid,
    input  logic                pop_ready,
    output baro_pkg::baro_item_t pop_item
);
    import baro_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    baro_item_t        slot_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg;
    logic [PW-1:0]     rd_ptr_reg;
    logic [CW-1:0]     count_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CW'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

>>> sv/baro_engine.sv
`timescale 1ns / 1ps

module baro_engine (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  baro_pkg::baro_item_t item,
    input  baro_pkg::baro_coef_t coef,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [63:0]          m_tdata
);
    import baro_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RECIP = 3'd1;
    localparam logic [2:0] ST_FIX   = 3'd2;
    localparam logic [2:0] ST_SCALE = 3'd3;
    localparam logic [2:0] ST_MUL   = 3'd4;
    localparam logic [2:0] ST_SUM   = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    localparam logic [2:0] OP_C20 = 3'd0;
    localparam logic [2:0] OP_C10 = 3'd1;
    localparam logic [2:0] OP_C00 = 3'd2;
    localparam logic [2:0] OP_C11 = 3'd3;
    localparam logic [2:0] OP_C01 = 3'd4;
    localparam logic [2:0] OP_T   = 3'd5;

    localparam logic [1:0] PH_LO  = 2'd0;
    localparam logic [1:0] PH_HI  = 2'd1;
    localparam logic [1:0] PH_ADD = 2'd2;

    localparam logic signed [73:0] HALF_LSB22 = 74'sd2097152;
    localparam logic signed [52:0] MAX48 = 53'sd140737488355327;
    localparam logic signed [52:0] MIN48 = -53'sd140737488355328;
    localparam logic signed [52:0] MAX32 = 53'sd2147483647;
    localparam logic signed [52:0] MIN32 = -53'sd2147483648;

    // magnitude of a raw value; on the long rates anything at or above 2^22
    // clips anyway, so hold it below that to keep the quotient in range
    function automatic logic [23:0] abs_clip(input logic signed [23:0] raw,
                                             input logic [2:0] code);
        logic [23:0] mag;
        mag = raw[23] ? 24'(~raw + 24'd1) : 24'(raw);
        if (code[2] && (mag[23:22] != 2'b00)) begin
            mag = 24'h3FFFFF;
        end
        return mag;
    endfunction

    // reciprocal estimate is exact or one low; the remainder, taken modulo
    // 2^12, fixes it and adds the round-half-away step in one go
    function automatic logic [27:0] recip_quot(input logic [55:0] prod,
                                               input logic [23:0] mag,
                                               input logic [2:0] code);
        logic [27:0] q0;
        logic [11:0] n_lo;
        logic [11:0] d;
        logic [11:0] qd;
        logic [12:0] r2;
        logic [12:0] d3;
        q0   = code[2] ? prod[49:22] : prod[55:28];
        n_lo = code[2] ? {mag[2:0], 9'd0} : {mag[8:0], 3'd0};
        d    = (12'd2 << code) - 12'd1;
        qd   = ((q0[11:0] << code) << 1) - q0[11:0];
        r2   = {12'(n_lo - qd), 1'b0};
        d3   = {1'b0, d} + {d, 1'b0};
        return q0 + 28'(r2 >= {1'b0, d}) + 28'(r2 >= d3);
    endfunction

    function automatic logic signed [23:0] quot_to_q22(input logic [27:0] q, input logic neg);
        if (!neg) begin
            return (q > 28'h07FFFFF) ? 24'sh7FFFFF : $signed(q[23:0]);
        end
        return (q > 28'h0800000) ? 24'sh800000 : $signed(~q[23:0] + 24'd1);
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [52:0] x);
        if (x > MAX48) return MAX48[47:0];
        if (x < MIN48) return MIN48[47:0];
        return x[47:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [52:0] x);
        if (x > MAX32) return MAX32[31:0];
        if (x < MIN32) return MIN32[31:0];
        return x[31:0];
    endfunction

    logic [2:0]          state_reg, state_next;
    logic [2:0]          op_reg;
    logic [1:0]          phase_reg;
    logic                m_tvalid_reg;
    logic [63:0]         m_tdata_reg;

    logic [23:0]         mag_p_reg, mag_t_reg;
    logic [55:0]         rprod_p_reg, rprod_t_reg;
    logic [27:0]         q_p_reg, q_t_reg;
    logic                neg_p_reg, neg_t_reg;
    logic signed [23:0]  p_reg, t_reg;
    logic signed [47:0]  a_reg, b_reg;
    logic signed [49:0]  prod_lo_reg, prod_hi_reg;
    logic signed [35:0]  tprod_reg;
    logic signed [47:0]  sum_reg;

    logic signed [47:0]  acc;
    logic signed [24:0]  mul_a, mul_b;
    logic signed [49:0]  mul_y;
    logic signed [73:0]  full;
    logic signed [51:0]  shifted;
    logic signed [19:0]  coef_sel;
    logic signed [47:0]  horner_v;
    logic signed [52:0]  pres_wide;
    logic signed [36:0]  temp_round;
    logic signed [31:0]  pres_out, temp_out;
    logic                out_free;
    logic                take;

    assign out_free   = !m_tvalid_reg || m_tready;
    assign item_ready = (state_reg == ST_IDLE);
    assign take       = item_valid && item_ready;
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;

    // shared 25x25 multiplier: low then high half of the accumulator
    always_comb begin
        acc   = (op_reg <= OP_C00) ? a_reg : b_reg;
        mul_a = (op_reg == OP_T) ? 25'(t_reg) : 25'(p_reg);
        mul_b = (phase_reg == PH_LO) ? $signed({1'b0, acc[23:0]})
                                     : 25'($signed(acc[47:24]));
        mul_y = mul_a * mul_b;
    end

    always_comb begin
        case (op_reg)
            OP_C20:  coef_sel = 20'(coef.c20);
            OP_C10:  coef_sel = coef.c10;
            OP_C00:  coef_sel = coef.c00;
            OP_C11:  coef_sel = 20'(coef.c11);
            OP_C01:  coef_sel = 20'(coef.c01);
            default: coef_sel = '0;
        endcase
        full     = (74'(prod_hi_reg) <<< 24) + 74'(prod_lo_reg) + HALF_LSB22;
        shifted  = $signed(full[73:22]);
        horner_v = sat48(53'(shifted) + (53'(coef_sel) <<< 14));
    end

    always_comb begin
        pres_wide  = (53'(sum_reg) + 53'sd128) >>> 8;
        pres_out   = sat32(pres_wide);
        temp_round = (37'(tprod_reg) + 37'sd8192) >>> 14;
        temp_out   = 32'(temp_round) + (32'(coef.c0) <<< 7);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (take) state_next = ST_RECIP;
            ST_RECIP: state_next = ST_FIX;
            ST_FIX:   state_next = ST_SCALE;
            ST_SCALE: state_next = ST_MUL;
            ST_MUL:   if (phase_reg == PH_ADD && op_reg == OP_T) state_next = ST_SUM;
            ST_SUM:   state_next = ST_OUT;
            ST_OUT:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            op_reg       <= OP_C20;
            phase_reg    <= PH_LO;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                ST_SCALE: begin
                    op_reg    <= OP_C20;
                    phase_reg <= PH_LO;
                end
                ST_MUL: begin
                    if (phase_reg == PH_ADD) begin
                        phase_reg <= PH_LO;
                        op_reg    <= op_reg + 3'd1;
                    end else begin
                        phase_reg <= phase_reg + 2'd1;
                    end
                end
                default: begin
                end
            endcase
            if (state_reg == ST_OUT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (take) begin
                    neg_p_reg <= item.raw_pressure[23];
                    neg_t_reg <= item.raw_temperature[23];
                    mag_p_reg <= abs_clip(item.raw_pressure, coef.prate);
                    mag_t_reg <= abs_clip(item.raw_temperature, coef.trate);
                end
            end
            ST_RECIP: begin
                rprod_p_reg <= 56'(mag_p_reg) * 56'(RATE_RECIP[coef.prate]);
                rprod_t_reg <= 56'(mag_t_reg) * 56'(RATE_RECIP[coef.trate]);
            end
            ST_FIX: begin
                q_p_reg <= recip_quot(rprod_p_reg, mag_p_reg, coef.prate);
                q_t_reg <= recip_quot(rprod_t_reg, mag_t_reg, coef.trate);
            end
            ST_SCALE: begin
                p_reg <= quot_to_q22(q_p_reg, neg_p_reg);
                t_reg <= quot_to_q22(q_t_reg, neg_t_reg);
                a_reg <= 48'(coef.c30) <<< 14;
                b_reg <= 48'(coef.c21) <<< 14;
            end
            ST_MUL: begin
                case (phase_reg)
                    PH_LO: begin
                        prod_lo_reg <= mul_y;
                        if (op_reg == OP_C20) begin
                            tprod_reg <= 36'(coef.c1) * 36'(t_reg);
                        end
                    end
                    PH_HI: begin
                        prod_hi_reg <= mul_y;
                    end
                    default: begin
                        if (op_reg <= OP_C00) begin
                            a_reg <= horner_v;
                        end else begin
                            b_reg <= horner_v;
                        end
                    end
                endcase
            end
            ST_SUM: begin
                sum_reg <= sat48(53'(a_reg) + 53'(b_reg));
            end
            ST_OUT: begin
                if (out_free) begin
                    m_tdata_reg <= {temp_out, pres_out};
                end
            end
            default: begin
            end
        endcase
    end

endmodule

>>> sv/baro_pressure_compensation.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake            Payload
// s_        in   s_tvalid/s_tready    s_tdata: raw_pressure, raw_temperature; s_tuser: temp_present
// m_        out  m_tvalid/m_tready    m_tdata: pressure_q6, temperature_q8
// cfg_      in   cfg_valid/cfg_ready  cfg_index, cfg_data (write only, always ready)
//
// In the engine each sample goes through a load, a reciprocal multiply and
// a rounding fix that scale pressure and temperature in parallel, a clip,
// six Horner terms on the shared 25x25 multiplier, then a sum and an output step.
// A queue of QUEUE_DEPTH samples sits between the front and the engine.
// Reset clears the registers, the stored temperature, the queue and the engine.
// A stalled result holds the engine in its output state; the queue accepts until it is full.

module baro_pressure_compensation #(
    parameter int QUEUE_DEPTH = baro_pkg::BARO_QUEUE_DEPTH
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [47:0]                      s_tdata,   // raw_pressure [23:0], raw_temperature [47:24]
    input  logic [0:0]                       s_tuser,   // temp_present [0]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [63:0]                      m_tdata,   // pressure_q6 [31:0], temperature_q8 [63:32]
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [baro_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [baro_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import baro_pkg::*;

    logic [19:0] offset_p_reg;
    logic [19:0] linear_p_reg;
    logic [15:0] temp_cross_reg;
    logic [15:0] temp_press_reg;
    logic [15:0] square_p_reg;
    logic [15:0] temp_square_p_reg;
    logic [15:0] cube_p_reg;
    logic [29:0] temp_rates_reg;

    baro_coef_t  coef;
    baro_item_t  push_item, pop_item;
    logic        push_valid, push_ready;
    logic        pop_valid, pop_ready;

    assign cfg_ready = 1'b1;

    // out-of-range indexes fall through and are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_p_reg      <= '0;
            linear_p_reg      <= '0;
            temp_cross_reg    <= '0;
            temp_press_reg    <= '0;
            square_p_reg      <= '0;
            temp_square_p_reg <= '0;
            cube_p_reg        <= '0;
            temp_rates_reg    <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_OFFSET_P:      offset_p_reg      <= cfg_data[19:0];
                REG_LINEAR_P:      linear_p_reg      <= cfg_data[19:0];
                REG_TEMP_CROSS:    temp_cross_reg    <= cfg_data[15:0];
                REG_TEMP_PRESS:    temp_press_reg    <= cfg_data[15:0];
                REG_SQUARE_P:      square_p_reg      <= cfg_data[15:0];
                REG_TEMP_SQUARE_P: temp_square_p_reg <= cfg_data[15:0];
                REG_CUBE_P:        cube_p_reg        <= cfg_data[15:0];
                REG_TEMP_RATES:    temp_rates_reg    <= cfg_data[29:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        coef.c00   = $signed(offset_p_reg);
        coef.c10   = $signed(linear_p_reg);
        coef.c01   = $signed(temp_cross_reg);
        coef.c11   = $signed(temp_press_reg);
        coef.c20   = $signed(square_p_reg);
        coef.c21   = $signed(temp_square_p_reg);
        coef.c30   = $signed(cube_p_reg);
        coef.c0    = $signed(temp_rates_reg[11:0]);
        coef.c1    = $signed(temp_rates_reg[23:12]);
        coef.prate = temp_rates_reg[26:24];
        coef.trate = temp_rates_reg[29:27];
    end

    baro_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    baro_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    baro_engine u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (pop_valid),
        .item_ready (pop_ready),
        .item       (pop_item),
        .coef       (coef),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule
